### rtl/sfc_pkg.sv
`timescale 1ns / 1ps

package sfc_pkg;

	localparam int REG_COUNT   = 6;
	localparam int PLANE_COUNT = 6;

	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int COEF_W  = 14;
	localparam int OFS_W   = 22;
	localparam int PROD_W  = COEF_W + COORD_W;
	localparam int DIST_W  = 40;
	localparam int HALF_W  = DIST_W / 2;
	localparam int SQ_W    = 2 * DIST_W;
	localparam int NORM_W  = 28;
	localparam int R2_W    = 2 * RAD_W;
	localparam int R2_HALF = RAD_W;
	localparam int RN_PART = R2_HALF + NORM_W;
	localparam int RN_W    = R2_W + NORM_W;

	typedef enum logic [2:0] {
		REG_PLANE_LEFT   = 3'd0,
		REG_PLANE_RIGHT  = 3'd1,
		REG_PLANE_TOP    = 3'd2,
		REG_PLANE_BOTTOM = 3'd3,
		REG_PLANE_NEAR   = 3'd4,
		REG_PLANE_FAR    = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] center_x;
		logic signed [COORD_W-1:0] center_y;
		logic signed [COORD_W-1:0] center_z;
		logic [RAD_W-1:0]          radius;
	} sphere_t;

	typedef struct packed {
		logic       visible;
		logic [2:0] planes_passed;
	} result_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
	} stage_en_t;

	function automatic logic signed [COEF_W-1:0] coef_a(input logic [63:0] p);
		return $signed(p[13:0]);
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_b(input logic [63:0] p);
		return $signed(p[27:14]);
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_c(input logic [63:0] p);
		return $signed(p[41:28]);
	endfunction

	function automatic logic signed [OFS_W-1:0] coef_d(input logic [63:0] p);
		return $signed(p[63:42]);
	endfunction

	// Squared length of the plane normal; never negative and below 2^28.
	function automatic logic [NORM_W-1:0] norm_sq(input logic [63:0] p);
		logic signed [NORM_W:0] a;
		logic signed [NORM_W:0] b;
		logic signed [NORM_W:0] c;
		logic signed [NORM_W:0] sum;
		a = (NORM_W+1)'(coef_a(p));
		b = (NORM_W+1)'(coef_b(p));
		c = (NORM_W+1)'(coef_c(p));
		sum = a * a + b * b + c * c;
		return sum[NORM_W-1:0];
	endfunction

endpackage

### rtl/sfc_lane.sv
`timescale 1ns / 1ps

module sfc_lane (
	input  logic                             clk,
	input  sfc_pkg::stage_en_t               en,
	input  sfc_pkg::sphere_t                 sphere,
	input  logic [sfc_pkg::R2_W-1:0]         r2_s1,
	input  logic [63:0]                      plane,
	input  logic [sfc_pkg::NORM_W-1:0]       n2,
	output logic                             fail_s6
);

	logic signed [sfc_pkg::PROD_W-1:0] px_s1;
	logic signed [sfc_pkg::PROD_W-1:0] py_s1;
	logic signed [sfc_pkg::PROD_W-1:0] pz_s1;

	logic signed [sfc_pkg::DIST_W-1:0] s_s2;
	logic [sfc_pkg::RN_PART-1:0]       rlo_s2;
	logic [sfc_pkg::RN_PART-1:0]       rhi_s2;

	logic                              neg_s3;
	logic [sfc_pkg::DIST_W-1:0]        as_s3;
	logic [sfc_pkg::RN_W-1:0]          rn_s3;

	logic                              neg_s4;
	logic [sfc_pkg::DIST_W-1:0]        hh_s4;
	logic [sfc_pkg::DIST_W-1:0]        hl_s4;
	logic [sfc_pkg::DIST_W-1:0]        ll_s4;
	logic [sfc_pkg::RN_W-1:0]          rn_s4;

	logic                              neg_s5;
	logic [sfc_pkg::SQ_W-1:0]          sq_s5;
	logic [sfc_pkg::RN_W-1:0]          rn_s5;

	logic signed [sfc_pkg::DIST_W-1:0] d_ext;
	logic [sfc_pkg::DIST_W-1:0]        s_u;
	logic [sfc_pkg::HALF_W-1:0]        as_hi;
	logic [sfc_pkg::HALF_W-1:0]        as_lo;

	assign d_ext = sfc_pkg::DIST_W'($signed({sfc_pkg::coef_d(plane), 12'b0}));
	assign s_u   = s_s2;
	assign as_hi = as_s3[sfc_pkg::DIST_W-1:sfc_pkg::HALF_W];
	assign as_lo = as_s3[sfc_pkg::HALF_W-1:0];

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			px_s1 <= sfc_pkg::PROD_W'(sfc_pkg::coef_a(plane)) * sfc_pkg::PROD_W'(sphere.center_x);
			py_s1 <= sfc_pkg::PROD_W'(sfc_pkg::coef_b(plane)) * sfc_pkg::PROD_W'(sphere.center_y);
			pz_s1 <= sfc_pkg::PROD_W'(sfc_pkg::coef_c(plane)) * sfc_pkg::PROD_W'(sphere.center_z);
		end
		if (en.en_s2) begin
			s_s2 <= sfc_pkg::DIST_W'(px_s1) + sfc_pkg::DIST_W'(py_s1)
				+ sfc_pkg::DIST_W'(pz_s1) + d_ext;
			rlo_s2 <= sfc_pkg::RN_PART'(r2_s1[sfc_pkg::R2_HALF-1:0]) * sfc_pkg::RN_PART'(n2);
			rhi_s2 <= sfc_pkg::RN_PART'(r2_s1[sfc_pkg::R2_W-1:sfc_pkg::R2_HALF])
				* sfc_pkg::RN_PART'(n2);
		end
		if (en.en_s3) begin
			neg_s3 <= s_u[sfc_pkg::DIST_W-1];
			as_s3  <= s_u[sfc_pkg::DIST_W-1] ? (~s_u + 1'b1) : s_u;
			rn_s3  <= (sfc_pkg::RN_W'(rhi_s2) << sfc_pkg::R2_HALF) + sfc_pkg::RN_W'(rlo_s2);
		end
		if (en.en_s4) begin
			neg_s4 <= neg_s3;
			hh_s4  <= sfc_pkg::DIST_W'(as_hi) * sfc_pkg::DIST_W'(as_hi);
			hl_s4  <= sfc_pkg::DIST_W'(as_hi) * sfc_pkg::DIST_W'(as_lo);
			ll_s4  <= sfc_pkg::DIST_W'(as_lo) * sfc_pkg::DIST_W'(as_lo);
			rn_s4  <= rn_s3;
		end
		if (en.en_s5) begin
			neg_s5 <= neg_s4;
			sq_s5  <= (sfc_pkg::SQ_W'(hh_s4) << sfc_pkg::DIST_W)
				+ (sfc_pkg::SQ_W'(hl_s4) << (sfc_pkg::HALF_W + 1))
				+ sfc_pkg::SQ_W'(ll_s4);
			rn_s5  <= rn_s4;
		end
		if (en.en_s6) begin
			fail_s6 <= neg_s5 && (n2 != '0) && (sq_s5 > sfc_pkg::SQ_W'(rn_s5));
		end
	end

endmodule

### rtl/sphere_frustum_cull.sv
`timescale 1ns / 1ps

// Tests a bounding sphere against six frustum planes held in configuration
// registers and reports whether it is visible and how many planes it passed
// before the first one it fails. One sphere is taken every cycle while
// sphere_stall is low; its result passes through the six stages of each
// plane lane (dot product, offset add, magnitude, split squaring,
// recombine, compare) and then the output register. A stall on the result
// side holds the pipeline only as far back as it has no empty stage. Plane
// registers must be written while no sphere is in flight.

module sphere_frustum_cull (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sphere_valid,
	output logic              sphere_stall,
	input  sfc_pkg::sphere_t  sphere,
	output logic              result_valid,
	input  logic              result_stall,
	output sfc_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	logic [63:0]                plane_q [sfc_pkg::REG_COUNT];
	logic [sfc_pkg::NORM_W-1:0] n2_q    [sfc_pkg::REG_COUNT];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en_s7;
	sfc_pkg::stage_en_t en;

	logic [sfc_pkg::R2_W-1:0]        r2_s1;
	logic [sfc_pkg::PLANE_COUNT-1:0] fail_s6;
	sfc_pkg::result_t                result_s7;
	logic [2:0]                      passed;
	logic                            cfg_hit;

	assign cfg_ready = 1'b1;

	always_comb begin
		case (cfg_index)
			sfc_pkg::REG_PLANE_LEFT,
			sfc_pkg::REG_PLANE_RIGHT,
			sfc_pkg::REG_PLANE_TOP,
			sfc_pkg::REG_PLANE_BOTTOM,
			sfc_pkg::REG_PLANE_NEAR,
			sfc_pkg::REG_PLANE_FAR: cfg_hit = 1'b1;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfc_pkg::REG_COUNT; i++) begin
				plane_q[i] <= '0;
				n2_q[i]    <= '0;
			end
		end else if (cfg_valid && cfg_ready && cfg_hit) begin
			plane_q[cfg_index] <= cfg_data;
			n2_q[cfg_index]    <= sfc_pkg::norm_sq(cfg_data);
		end
	end

	assign en_s7    = !v_s7 || !result_stall;
	assign en.en_s6 = !v_s6 || en_s7;
	assign en.en_s5 = !v_s5 || en.en_s6;
	assign en.en_s4 = !v_s4 || en.en_s5;
	assign en.en_s3 = !v_s3 || en.en_s4;
	assign en.en_s2 = !v_s2 || en.en_s3;
	assign en.en_s1 = !v_s1 || en.en_s2;

	assign sphere_stall = !en.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en.en_s1) v_s1 <= sphere_valid;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
			if (en.en_s4) v_s4 <= v_s3;
			if (en.en_s5) v_s5 <= v_s4;
			if (en.en_s6) v_s6 <= v_s5;
			if (en_s7)    v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			r2_s1 <= sfc_pkg::R2_W'(sphere.radius) * sfc_pkg::R2_W'(sphere.radius);
		end
	end

	for (genvar g = 0; g < sfc_pkg::PLANE_COUNT; g++) begin : g_lane
		sfc_lane u_lane (
			.clk     (clk),
			.en      (en),
			.sphere  (sphere),
			.r2_s1   (r2_s1),
			.plane   (plane_q[g]),
			.n2      (n2_q[g]),
			.fail_s6 (fail_s6[g])
		);
	end

	// The lowest failing plane sets the count.
	always_comb begin
		passed = 3'(sfc_pkg::PLANE_COUNT);
		for (int i = sfc_pkg::PLANE_COUNT - 1; i >= 0; i--) begin
			if (fail_s6[i]) begin
				passed = 3'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7) begin
			result_s7.visible       <= (passed == 3'(sfc_pkg::PLANE_COUNT));
			result_s7.planes_passed <= passed;
		end
	end

	assign result_valid = v_s7;
	assign result       = result_s7;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sphere_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && v_s6 && v_s7))
		else $error("input stalled while the pipeline has an empty stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(sphere_valid && !sphere_stall) |=> v_s1)
		else $error("accepted word did not enter the first stage");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.planes_passed <= 3'(sfc_pkg::PLANE_COUNT)))
		else $error("plane count out of range");

	a_held_result_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("held word changed while the output was stalled");

endmodule
